// ===== rtl/ftda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point to decimal ASCII formatter package
// Shared widths, character codes, slot codes and the item type that travels
// down the digit conversion chain.
// ----------------------------------------------------------------------------
package ftda_pkg;

   localparam int VALUE_W             = 39;
   localparam int CFG_W               = 3;
   localparam int FRACTION_BITS       = 24;
   localparam int INTEGER_DIGITS      = 4;
   localparam int MAX_FRACTION_DIGITS = 6;

   function automatic longint unsigned pow10(input int n);
      longint unsigned r;
      r = 64'd1;
      for (int i = 0; i < n; i++) begin
         r = r * 64'd10;
      end
      return r;
   endfunction

   localparam int              TOTAL_DIGITS = INTEGER_DIGITS + MAX_FRACTION_DIGITS;
   localparam longint unsigned SCALE        = pow10(MAX_FRACTION_DIGITS);
   localparam longint unsigned LIMIT        = pow10(TOTAL_DIGITS);
   localparam int              SCALE_W      = $clog2(SCALE + 1);
   localparam int              PROD_W       = VALUE_W + SCALE_W;
   localparam int              BIN_W        = PROD_W - FRACTION_BITS;
   localparam int              BCD_W        = 4 * TOTAL_DIGITS;
   localparam int              NUM_CELLS    = BIN_W;
   localparam int              DIGITS_W     = $clog2(MAX_FRACTION_DIGITS + 1);
   localparam int              SLOT_W       = $clog2(TOTAL_DIGITS + 2);
   localparam int              DIGIT_IDX_W  = $clog2(TOTAL_DIGITS);

   localparam logic [CFG_W-1:0] FRACTION_DIGITS_RESET = 3'd6;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [SLOT_W-1:0] SLOT_SIGN  = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_POINT = SLOT_W'(INTEGER_DIGITS + 1);

   typedef struct packed {
      logic                neg;
      logic                err;
      logic [DIGITS_W-1:0] nd;
      logic [BIN_W-1:0]    bin;
      logic [BCD_W-1:0]    bcd;
   } ftda_item_type;

endpackage
`default_nettype wire

// ===== rtl/fixed_to_decimal_ascii_core.sv =====
// The first character of a number leaves through two scaling stages, one
// conversion cell per bit, the serializer buffer and its output register.
// Throughput: one character per cycle while rsp_ready holds; a number has as
// many characters as the serializer sets, 1 for an error and up to 12.
// Reset clears all valid state and sets fraction_digits to 6.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point to decimal ASCII formatter
// Rounds a signed fixed-point number to six decimal places and sends its
// decimal text one character per beat.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [ftda_pkg::VALUE_W-1:0] req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [7:0]                               rsp_character,
   output logic                                     rsp_last_char,
   output logic                                     rsp_out_of_range,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ftda_pkg::CFG_W-1:0]          csr_fraction_digits
);
   import ftda_pkg::*;

   logic [CFG_W-1:0]    cfg_ff;
   logic [DIGITS_W-1:0] nd;
   logic                advance;
   logic                take_ok;
   logic [NUM_CELLS:0]  chain_valid;
   ftda_item_type       chain_item [NUM_CELLS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= FRACTION_DIGITS_RESET;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= csr_fraction_digits;
      end
   end

   assign csr_ready = 1'b1;
   assign nd = (cfg_ff > CFG_W'(MAX_FRACTION_DIGITS)) ? DIGITS_W'(MAX_FRACTION_DIGITS)
                                                       : DIGITS_W'(cfg_ff);

   assign advance   = !chain_valid[NUM_CELLS] || take_ok;
   assign req_ready = advance;

   ftda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_value (req_value),
      .nd        (nd),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0])
   );

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      ftda_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[c]),
         .in_item   (chain_item[c]),
         .out_valid (chain_valid[c+1]),
         .out_item  (chain_item[c+1])
      );
   end

   ftda_serializer u_serializer (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (chain_valid[NUM_CELLS]),
      .in_item          (chain_item[NUM_CELLS]),
      .take_ok          (take_ok),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last_char    (rsp_last_char),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule
`default_nettype wire

// ===== rtl/ftda_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Formatter front end
// Takes the magnitude of the input, scales it by the decimal fraction scale
// with round half up, and flags values beyond the integer digit range.
// ----------------------------------------------------------------------------
module ftda_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         req_valid,
   input  wire logic signed [ftda_pkg::VALUE_W-1:0] req_value,
   input  wire logic [ftda_pkg::DIGITS_W-1:0] nd,
   output logic                              out_valid,
   output ftda_pkg::ftda_item_type           out_item
);
   import ftda_pkg::*;

   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRACTION_BITS - 1);

   logic                s0_valid_ff;
   logic                s0_neg_ff;
   logic [DIGITS_W-1:0] s0_nd_ff;
   logic [VALUE_W-1:0]  s0_mag_ff;
   logic [VALUE_W-1:0]  s0_mag_in;

   logic                s1_valid_ff;
   logic                s1_neg_ff;
   logic [DIGITS_W-1:0] s1_nd_ff;
   logic [PROD_W-1:0]   s1_prod_ff;
   logic [PROD_W-1:0]   s1_prod_in;

   logic [BIN_W-1:0]    scaled;

   assign s0_mag_in  = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;
   assign s1_prod_in = PROD_W'(s0_mag_ff) * PROD_W'(SCALE) + HALF;
   assign scaled     = s1_prod_ff[PROD_W-1:FRACTION_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_neg_ff  <= req_value[VALUE_W-1];
         s0_nd_ff   <= nd;
         s0_mag_ff  <= s0_mag_in;
         s1_neg_ff  <= s0_neg_ff;
         s1_nd_ff   <= s0_nd_ff;
         s1_prod_ff <= s1_prod_in;
      end
   end

   always_comb begin
      out_valid    = s1_valid_ff;
      out_item.neg = s1_neg_ff;
      out_item.err = (64'(scaled) >= LIMIT);
      out_item.nd  = s1_nd_ff;
      out_item.bin = scaled;
      out_item.bcd = '0;
   end

endmodule
`default_nettype wire

// ===== rtl/ftda_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary to BCD conversion cell
// One shift-and-add-three step: corrects every BCD digit, then shifts the
// next binary bit into the BCD word and hands the item to the next cell.
// ----------------------------------------------------------------------------
module ftda_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire ftda_pkg::ftda_item_type in_item,
   output logic                         out_valid,
   output ftda_pkg::ftda_item_type      out_item
);
   import ftda_pkg::*;

   logic          valid_ff;
   ftda_item_type item_ff;
   ftda_item_type item_in;
   logic [BCD_W-1:0] corr;

   always_comb begin
      corr = in_item.bcd;
      for (int d = 0; d < TOTAL_DIGITS; d++) begin
         if (corr[4*d +: 4] >= 4'd5) begin
            corr[4*d +: 4] = corr[4*d +: 4] + 4'd3;
         end
      end
      item_in     = in_item;
      item_in.bcd = {corr[BCD_W-2:0], in_item.bin[BIN_W-1]};
      item_in.bin = {in_item.bin[BIN_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// ===== rtl/ftda_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Character serializer
// Holds one converted number and sends its characters one beat at a time
// through a registered output stage.
// ----------------------------------------------------------------------------
module ftda_serializer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire ftda_pkg::ftda_item_type in_item,
   output logic                         take_ok,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last_char,
   output logic                         rsp_out_of_range
);
   import ftda_pkg::*;

   logic                buf_valid_ff;
   logic                buf_err_ff;
   logic [SLOT_W-1:0]   buf_pos_ff;
   logic [SLOT_W-1:0]   buf_pos_in;
   logic [SLOT_W-1:0]   buf_end_ff;
   logic [SLOT_W-1:0]   buf_lz_ff;
   logic [BCD_W-1:0]    buf_bcd_ff;

   logic                rsp_valid_ff;
   logic [7:0]          rsp_character_ff;
   logic                rsp_last_char_ff;
   logic                rsp_out_of_range_ff;

   logic                out_move;
   logic                emit;
   logic                buf_last;
   logic                load;
   logic [SLOT_W-1:0]   lz;
   logic                found;
   logic [SLOT_W-1:0]   start;
   logic [SLOT_W-1:0]   idx_slot;
   logic [DIGIT_IDX_W-1:0] digit_idx;
   logic [3:0]          digit;
   logic [7:0]          char_in;

   always_comb begin
      lz    = '0;
      found = 1'b0;
      for (int i = 0; i < INTEGER_DIGITS - 1; i++) begin
         if (!found && in_item.bcd[4*(TOTAL_DIGITS-1-i) +: 4] == 4'd0) begin
            lz = lz + SLOT_W'(1);
         end else begin
            found = 1'b1;
         end
      end
      start = in_item.neg ? SLOT_SIGN : (lz + SLOT_W'(1));
   end

   assign out_move = !rsp_valid_ff || rsp_ready;
   assign emit     = buf_valid_ff && out_move;
   assign buf_last = buf_err_ff || (buf_pos_ff == buf_end_ff);
   assign take_ok  = !buf_valid_ff || (emit && buf_last);
   assign load     = in_valid && take_ok;

   assign buf_pos_in = (buf_pos_ff == SLOT_SIGN) ? (buf_lz_ff + SLOT_W'(1))
                                                 : (buf_pos_ff + SLOT_W'(1));

   always_comb begin
      if (buf_pos_ff <= SLOT_W'(INTEGER_DIGITS)) begin
         idx_slot = SLOT_W'(TOTAL_DIGITS) - buf_pos_ff;
      end else begin
         idx_slot = SLOT_W'(TOTAL_DIGITS + 1) - buf_pos_ff;
      end
      digit_idx = idx_slot[DIGIT_IDX_W-1:0];
      digit     = buf_bcd_ff[digit_idx*4 +: 4];
      if (buf_err_ff) begin
         char_in = CHAR_NUL;
      end else if (buf_pos_ff == SLOT_SIGN) begin
         char_in = CHAR_MINUS;
      end else if (buf_pos_ff == SLOT_POINT) begin
         char_in = CHAR_POINT;
      end else begin
         char_in = CHAR_ZERO + {4'd0, digit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            buf_valid_ff <= 1'b1;
         end else if (emit && buf_last) begin
            buf_valid_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_err_ff <= in_item.err;
         buf_pos_ff <= start;
         buf_end_ff <= SLOT_POINT + SLOT_W'(in_item.nd);
         buf_lz_ff  <= lz;
         buf_bcd_ff <= in_item.bcd;
      end else if (emit) begin
         buf_pos_ff <= buf_pos_in;
      end
      if (emit) begin
         rsp_character_ff    <= char_in;
         rsp_last_char_ff    <= buf_last;
         rsp_out_of_range_ff <= buf_err_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_character    = rsp_character_ff;
   assign rsp_last_char    = rsp_last_char_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;

endmodule
`default_nettype wire
